FILE: hdl/lav_pkg.sv
// Shared types and constants for the look-at view matrix block.
// Holds the transaction payload structs and the fixed word format.
// No dependencies.
package lav_pkg;

   localparam int LAV_WORD_BITS  = 32;
   localparam int LAV_FRAC_BITS  = 16;
   // magnitude width after block scaling: largest component in [2^29, 2^30)
   localparam int LAV_SCALE_BITS = 30;

   localparam logic [1:0] LAV_LAST_COL = 2'd3;

   typedef struct packed {
      logic signed [LAV_WORD_BITS-1:0] eye_x;
      logic signed [LAV_WORD_BITS-1:0] eye_y;
      logic signed [LAV_WORD_BITS-1:0] eye_z;
      logic signed [LAV_WORD_BITS-1:0] target_x;
      logic signed [LAV_WORD_BITS-1:0] target_y;
      logic signed [LAV_WORD_BITS-1:0] target_z;
      logic signed [LAV_WORD_BITS-1:0] up_x;
      logic signed [LAV_WORD_BITS-1:0] up_y;
      logic signed [LAV_WORD_BITS-1:0] up_z;
   } req_type;

   typedef struct packed {
      logic [1:0]                      column_index;
      logic signed [LAV_WORD_BITS-1:0] row_zero;
      logic signed [LAV_WORD_BITS-1:0] row_one;
      logic signed [LAV_WORD_BITS-1:0] row_two;
      logic signed [LAV_WORD_BITS-1:0] row_three;
      logic                            last_column;
   } rsp_type;

endpackage

FILE: hdl/lav_scale.sv
// Block scaling pipeline: scales a 3-vector by a common power of two so that
// its largest magnitude has its leading one at bit 29. One shift step per stage.
// Depends on lav_pkg.
module lav_scale #(
   parameter int IW = 32,
   parameter int SW = 1
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          adv,
   input  logic                                          in_valid,
   input  logic [2:0][IW-1:0]                            in_vec,
   input  logic [SW-1:0]                                 in_side,
   output logic                                          out_valid,
   output logic [2:0][lav_pkg::LAV_SCALE_BITS-1:0]       out_mag,
   output logic [2:0]                                    out_neg,
   output logic                                          out_nz,
   output logic [SW-1:0]                                 out_side
);
   localparam int MB = lav_pkg::LAV_SCALE_BITS;
   localparam int NW = IW + MB;
   localparam int NS = $clog2(NW);

   logic [NW-1:0] mag_ff  [NS+1][3];
   logic [NW-1:0] mag_in  [NS+1][3];
   logic [NW-1:0] or_ff   [NS+1];
   logic [NW-1:0] or_in   [NS+1];
   logic [2:0]    neg_ff  [NS+1];
   logic [2:0]    neg_in;
   logic [SW-1:0] side_ff [NS+1];
   logic [NS:0]   valid_ff;

   // take magnitudes, then shift left by halving steps while the top is empty
   always_comb begin
      logic [IW-1:0] absv;
      logic          tz;
      or_in[0] = '0;
      for (int i = 0; i < 3; i++) begin
         neg_in[i]    = in_vec[i][IW-1];
         absv         = neg_in[i] ? (IW'(0) - in_vec[i]) : in_vec[i];
         mag_in[0][i] = {absv, {MB{1'b0}}};
         or_in[0]     = or_in[0] | mag_in[0][i];
      end
      for (int j = 0; j < NS; j++) begin
         tz = ((or_ff[j] >> (NW - (1 << (NS - 1 - j)))) == '0);
         or_in[j+1] = tz ? (or_ff[j] << (1 << (NS - 1 - j))) : or_ff[j];
         for (int i = 0; i < 3; i++) begin
            mag_in[j+1][i] = tz ? (mag_ff[j][i] << (1 << (NS - 1 - j))) : mag_ff[j][i];
         end
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff[0]  <= neg_in;
         side_ff[0] <= in_side;
         for (int j = 0; j <= NS; j++) begin
            or_ff[j]  <= or_in[j];
            mag_ff[j] <= mag_in[j];
         end
         for (int j = 0; j < NS; j++) begin
            neg_ff[j+1]  <= neg_ff[j];
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NS-1:0], in_valid};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_mag[i] = mag_ff[NS][i][NW-1 -: MB];
      end
   end
   assign out_neg   = neg_ff[NS];
   assign out_nz    = or_ff[NS][NW-1];
   assign out_side  = side_ff[NS];
   assign out_valid = valid_ff[NS];

endmodule

FILE: hdl/lav_unit.sv
// Vector normalisation pipeline: block scaling, sum of squares, bit-serial
// integer square root and restoring division, one step per stage.
// Depends on lav_pkg and lav_scale.
module lav_unit #(
   parameter int IW = 33,
   parameter int SW = 1,
   parameter int FB = lav_pkg::LAV_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [2:0][IW-1:0]   in_vec,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic [2:0][FB+1:0]   out_vec,
   output logic [SW-1:0]        out_side
);
   localparam int MB   = lav_pkg::LAV_SCALE_BITS;
   localparam int SQW  = 2 * MB;
   localparam int SXW  = SQW + 2;
   localparam int SQ_N = MB + 1;
   localparam int LW   = MB + 1;
   localparam int DRW  = FB + MB + 2;
   localparam int DV_N = FB + 1;
   localparam int VL   = SQ_N + DV_N + 4;

   logic                    sc_valid;
   logic [2:0][MB-1:0]      sc_mag;
   logic [2:0]              sc_neg;
   logic                    sc_nz;
   logic [SW-1:0]           sc_side;

   lav_scale #(.IW(IW), .SW(SW)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_valid),
      .in_vec    (in_vec),
      .in_side   (in_side),
      .out_valid (sc_valid),
      .out_mag   (sc_mag),
      .out_neg   (sc_neg),
      .out_nz    (sc_nz),
      .out_side  (sc_side)
   );

   // squaring stage
   logic [MB-1:0]  mm_ff [3];
   logic [SQW-1:0] sq_ff [3];
   logic [2:0]     mneg_ff;
   logic           mnz_ff;
   logic [SW-1:0]  mside_ff;

   // square root stages
   logic [SXW-1:0] sx_ff    [SQ_N+1];
   logic [SXW-1:0] sx_in    [SQ_N+1];
   logic [SXW-1:0] sr_ff    [SQ_N+1];
   logic [SXW-1:0] sr_in    [SQ_N+1];
   logic [MB-1:0]  smag_ff  [SQ_N+1][3];
   logic [2:0]     sneg_ff  [SQ_N+1];
   logic           snz_ff   [SQ_N+1];
   logic [SW-1:0]  sside_ff [SQ_N+1];

   // division stages
   logic [DRW-1:0] rem_ff   [DV_N+1][3];
   logic [DRW-1:0] rem_in   [DV_N+1][3];
   logic [FB:0]    q_ff     [DV_N+1][3];
   logic [FB:0]    q_in     [DV_N+1][3];
   logic [LW-1:0]  dlen_ff  [DV_N+1];
   logic [2:0]     dneg_ff  [DV_N+1];
   logic           dnz_ff   [DV_N+1];
   logic [SW-1:0]  dside_ff [DV_N+1];

   logic [2:0][FB+1:0] ov_in;
   logic [2:0][FB+1:0] ov_ff;
   logic [SW-1:0]      oside_ff;
   logic [VL-1:0]      vld_ff;

   // square root: one result bit per stage
   always_comb begin
      logic [SXW-1:0] t;
      logic [SXW-1:0] b;
      sx_in[0] = SXW'(sq_ff[0]) + SXW'(sq_ff[1]) + SXW'(sq_ff[2]);
      sr_in[0] = '0;
      for (int j = 1; j <= SQ_N; j++) begin
         b = SXW'(1) << (SXW - 2 * j);
         t = sr_ff[j-1] + b;
         if (sx_ff[j-1] >= t) begin
            sx_in[j] = sx_ff[j-1] - t;
            sr_in[j] = (sr_ff[j-1] >> 1) + b;
         end else begin
            sx_in[j] = sx_ff[j-1];
            sr_in[j] = sr_ff[j-1] >> 1;
         end
      end
   end

   // restoring division: one quotient bit per stage, rounding offset added up front
   always_comb begin
      logic [DRW-1:0] d;
      logic [LW-1:0]  len;
      len = sr_ff[SQ_N][LW-1:0];
      for (int i = 0; i < 3; i++) begin
         rem_in[0][i] = DRW'({smag_ff[SQ_N][i], {FB{1'b0}}}) + DRW'(len >> 1);
         q_in[0][i]   = '0;
      end
      for (int j = 1; j <= DV_N; j++) begin
         d = DRW'(dlen_ff[j-1]) << (DV_N - j);
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[j-1][i] >= d) begin
               rem_in[j][i] = rem_ff[j-1][i] - d;
               q_in[j][i]   = q_ff[j-1][i] | ((FB+1)'(1) << (DV_N - j));
            end else begin
               rem_in[j][i] = rem_ff[j-1][i];
               q_in[j][i]   = q_ff[j-1][i];
            end
         end
      end
   end

   // restore signs; a zero vector passes through as zero
   always_comb begin
      logic [FB+1:0] qe;
      for (int i = 0; i < 3; i++) begin
         qe = (FB+2)'(q_ff[DV_N][i]);
         if (!dnz_ff[DV_N]) begin
            ov_in[i] = '0;
         end else if (dneg_ff[DV_N][i]) begin
            ov_in[i] = (FB+2)'(0) - qe;
         end else begin
            ov_in[i] = qe;
         end
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            mm_ff[i] <= sc_mag[i];
            sq_ff[i] <= SQW'(sc_mag[i]) * SQW'(sc_mag[i]);
         end
         mneg_ff  <= sc_neg;
         mnz_ff   <= sc_nz;
         mside_ff <= sc_side;

         for (int j = 0; j <= SQ_N; j++) begin
            sx_ff[j] <= sx_in[j];
            sr_ff[j] <= sr_in[j];
         end
         smag_ff[0]  <= mm_ff;
         sneg_ff[0]  <= mneg_ff;
         snz_ff[0]   <= mnz_ff;
         sside_ff[0] <= mside_ff;
         for (int j = 1; j <= SQ_N; j++) begin
            smag_ff[j]  <= smag_ff[j-1];
            sneg_ff[j]  <= sneg_ff[j-1];
            snz_ff[j]   <= snz_ff[j-1];
            sside_ff[j] <= sside_ff[j-1];
         end

         for (int j = 0; j <= DV_N; j++) begin
            rem_ff[j] <= rem_in[j];
            q_ff[j]   <= q_in[j];
         end
         dlen_ff[0]  <= sr_ff[SQ_N][LW-1:0];
         dneg_ff[0]  <= sneg_ff[SQ_N];
         dnz_ff[0]   <= snz_ff[SQ_N];
         dside_ff[0] <= sside_ff[SQ_N];
         for (int j = 1; j <= DV_N; j++) begin
            dlen_ff[j]  <= dlen_ff[j-1];
            dneg_ff[j]  <= dneg_ff[j-1];
            dnz_ff[j]   <= dnz_ff[j-1];
            dside_ff[j] <= dside_ff[j-1];
         end

         ov_ff    <= ov_in;
         oside_ff <= dside_ff[DV_N];
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[VL-2:0], sc_valid};
      end
   end

   assign out_valid = vld_ff[VL-1];
   assign out_vec   = ov_ff;
   assign out_side  = oside_ff;

endmodule

FILE: hdl/look_at_view_matrix.sv
// Look-at view matrix: takes eye, target and up in signed fixed point and
// returns the 4x4 view matrix as four column transactions, column 0 first.
// Depends on lav_pkg, lav_unit and lav_scale.
//
// The datapath is one long pipeline: block scaling of the up vector, three
// normalisation units (front, side, top) each built from a bit-per-stage
// square root and a bit-per-stage divider, two cross products and the eye dot
// products. A new transaction can enter on any cycle the pipeline advances.
// Sustained throughput is set by the result port, which carries one matrix
// column per cycle while rsp_ready is high. While the column serialiser is
// still draining, the pipeline keeps accepting until its last stage holds a
// finished matrix; then req_ready falls until the serialiser frees up.
module look_at_view_matrix #(
   parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lav_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lav_pkg::rsp_type rsp_data
);
   localparam int W   = lav_pkg::LAV_WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int MB  = lav_pkg::LAV_SCALE_BITS;
   localparam int UB  = MB + 1;
   localparam int QB  = F + 2;
   localparam int PW1 = QB + UB;
   localparam int CW1 = PW1 + 1;
   localparam int PW2 = 2 * QB;
   localparam int CW2 = PW2 + 1;
   localparam int SW0 = 3 * W + 3 * (W + 1);
   localparam int SW1 = 3 * W + 3 * UB;
   localparam int SW2 = 3 * W + 3 * QB;
   localparam int SW3 = 3 * W + 6 * QB;
   localparam int HB  = W + 2;
   localparam int LB  = 2 * F + 3;
   localparam int HS  = HB + 2;
   localparam int LS  = LB + 2;
   localparam int DW  = W + F + 8;
   localparam logic signed [DW-1:0] ONE_D  = DW'(1) <<< F;
   localparam logic signed [DW-1:0] HALF_D = DW'(1) <<< (F - 1);

   function automatic logic [W-1:0] sat_word(input logic signed [DW-1:0] v);
      if (v[DW-1:W-1] == '0 || v[DW-1:W-1] == '1) begin
         return v[W-1:0];
      end
      return v[DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
   endfunction

   function automatic logic signed [PW1-1:0] mul_fu(input logic [QB-1:0] a,
                                                   input logic [UB-1:0] b);
      return PW1'($signed(a)) * PW1'($signed(b));
   endfunction

   function automatic logic signed [PW2-1:0] mul_ff(input logic [QB-1:0] a,
                                                   input logic [QB-1:0] b);
      return PW2'($signed(a)) * PW2'($signed(b));
   endfunction

   logic adv;
   logic ser_free;
   logic load;

   // input stage
   logic                s0_v_ff;
   logic [2:0][W-1:0]   eye0_ff;
   logic [2:0][W:0]     diff0_ff;
   logic [2:0][W-1:0]   up0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         eye0_ff[0]  <= req_data.eye_x;
         eye0_ff[1]  <= req_data.eye_y;
         eye0_ff[2]  <= req_data.eye_z;
         up0_ff[0]   <= req_data.up_x;
         up0_ff[1]   <= req_data.up_y;
         up0_ff[2]   <= req_data.up_z;
         diff0_ff[0] <= (W+1)'(req_data.target_x) - (W+1)'(req_data.eye_x);
         diff0_ff[1] <= (W+1)'(req_data.target_y) - (W+1)'(req_data.eye_y);
         diff0_ff[2] <= (W+1)'(req_data.target_z) - (W+1)'(req_data.eye_z);
      end
   end

   // scale the up vector, keeping its direction
   logic               us_valid;
   logic [2:0][MB-1:0] us_mag;
   logic [2:0]         us_neg;
   logic               us_nz;
   logic [SW0-1:0]     us_side;
   logic [2:0][UB-1:0] upd;

   lav_scale #(.IW(W), .SW(SW0)) u_up (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s0_v_ff),
      .in_vec    (up0_ff),
      .in_side   ({eye0_ff, diff0_ff}),
      .out_valid (us_valid),
      .out_mag   (us_mag),
      .out_neg   (us_neg),
      .out_nz    (us_nz),
      .out_side  (us_side)
   );

   // a zero up vector has zero magnitudes already
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (us_nz && us_neg[i]) begin
            upd[i] = UB'(0) - UB'(us_mag[i]);
         end else begin
            upd[i] = UB'(us_mag[i]);
         end
      end
   end

   // front = normalize(target - eye)
   logic               fr_valid;
   logic [2:0][QB-1:0] fr_vec;
   logic [SW1-1:0]     fr_side;
   logic [2:0][W-1:0]  eye_a;
   logic [2:0][W:0]    diff_a;
   logic [2:0][W-1:0]  eye_b;
   logic [2:0][UB-1:0] upd_b;

   assign eye_a  = us_side[SW0-1 -: 3*W];
   assign diff_a = us_side[3*(W+1)-1:0];

   lav_unit #(.IW(W+1), .SW(SW1), .FB(F)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (us_valid),
      .in_vec    (diff_a),
      .in_side   ({eye_a, upd}),
      .out_valid (fr_valid),
      .out_vec   (fr_vec),
      .out_side  (fr_side)
   );

   assign eye_b = fr_side[SW1-1 -: 3*W];
   assign upd_b = fr_side[3*UB-1:0];

   // front x up: products, then differences
   logic                  x1_v_ff;
   logic signed [PW1-1:0] x1p_ff [6];
   logic [2:0][W-1:0]     x1eye_ff;
   logic [2:0][QB-1:0]    x1f_ff;
   logic                  x2_v_ff;
   logic [2:0][CW1-1:0]   cr1_ff;
   logic [2:0][W-1:0]     x2eye_ff;
   logic [2:0][QB-1:0]    x2f_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x1p_ff[0] <= mul_fu(fr_vec[1], upd_b[2]);
         x1p_ff[1] <= mul_fu(fr_vec[2], upd_b[1]);
         x1p_ff[2] <= mul_fu(fr_vec[2], upd_b[0]);
         x1p_ff[3] <= mul_fu(fr_vec[0], upd_b[2]);
         x1p_ff[4] <= mul_fu(fr_vec[0], upd_b[1]);
         x1p_ff[5] <= mul_fu(fr_vec[1], upd_b[0]);
         x1eye_ff  <= eye_b;
         x1f_ff    <= fr_vec;
         cr1_ff[0] <= CW1'(x1p_ff[0]) - CW1'(x1p_ff[1]);
         cr1_ff[1] <= CW1'(x1p_ff[2]) - CW1'(x1p_ff[3]);
         cr1_ff[2] <= CW1'(x1p_ff[4]) - CW1'(x1p_ff[5]);
         x2eye_ff  <= x1eye_ff;
         x2f_ff    <= x1f_ff;
      end
   end

   // side = normalize(front x up)
   logic               sd_valid;
   logic [2:0][QB-1:0] sd_vec;
   logic [SW2-1:0]     sd_side;
   logic [2:0][W-1:0]  eye_c;
   logic [2:0][QB-1:0] front_c;

   lav_unit #(.IW(CW1), .SW(SW2), .FB(F)) u_side (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (x2_v_ff),
      .in_vec    (cr1_ff),
      .in_side   ({x2eye_ff, x2f_ff}),
      .out_valid (sd_valid),
      .out_vec   (sd_vec),
      .out_side  (sd_side)
   );

   assign eye_c   = sd_side[SW2-1 -: 3*W];
   assign front_c = sd_side[3*QB-1:0];

   // side x front: products, then differences
   logic                  y1_v_ff;
   logic signed [PW2-1:0] y1p_ff [6];
   logic [2:0][W-1:0]     y1eye_ff;
   logic [2:0][QB-1:0]    y1f_ff;
   logic [2:0][QB-1:0]    y1s_ff;
   logic                  y2_v_ff;
   logic [2:0][CW2-1:0]   cr2_ff;
   logic [2:0][W-1:0]     y2eye_ff;
   logic [2:0][QB-1:0]    y2f_ff;
   logic [2:0][QB-1:0]    y2s_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         y1p_ff[0] <= mul_ff(sd_vec[1], front_c[2]);
         y1p_ff[1] <= mul_ff(sd_vec[2], front_c[1]);
         y1p_ff[2] <= mul_ff(sd_vec[2], front_c[0]);
         y1p_ff[3] <= mul_ff(sd_vec[0], front_c[2]);
         y1p_ff[4] <= mul_ff(sd_vec[0], front_c[1]);
         y1p_ff[5] <= mul_ff(sd_vec[1], front_c[0]);
         y1eye_ff  <= eye_c;
         y1f_ff    <= front_c;
         y1s_ff    <= sd_vec;
         cr2_ff[0] <= CW2'(y1p_ff[0]) - CW2'(y1p_ff[1]);
         cr2_ff[1] <= CW2'(y1p_ff[2]) - CW2'(y1p_ff[3]);
         cr2_ff[2] <= CW2'(y1p_ff[4]) - CW2'(y1p_ff[5]);
         y2eye_ff  <= y1eye_ff;
         y2f_ff    <= y1f_ff;
         y2s_ff    <= y1s_ff;
      end
   end

   // top = normalize(side x front)
   logic               tp_valid;
   logic [2:0][QB-1:0] tp_vec;
   logic [SW3-1:0]     tp_side;
   logic [2:0][W-1:0]  eye_d;
   logic [2:0][QB-1:0] front_d;
   logic [2:0][QB-1:0] side_d;

   lav_unit #(.IW(CW2), .SW(SW3), .FB(F)) u_top (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (y2_v_ff),
      .in_vec    (cr2_ff),
      .in_side   ({y2eye_ff, y2f_ff, y2s_ff}),
      .out_valid (tp_valid),
      .out_vec   (tp_vec),
      .out_side  (tp_side)
   );

   assign eye_d   = tp_side[SW3-1 -: 3*W];
   assign front_d = tp_side[6*QB-1 -: 3*QB];
   assign side_d  = tp_side[3*QB-1:0];

   // eye dot products: integer and fraction parts of the eye apart
   // basis index: 0 side, 1 top, 2 front
   logic                  d1_v_ff;
   logic signed [HB-1:0]  d1h_ff [3][3];
   logic signed [LB-1:0]  d1l_ff [3][3];
   logic [2:0][QB-1:0]    d1b_ff [3];
   logic                  d2_v_ff;
   logic signed [HS-1:0]  d2h_ff [3];
   logic signed [LS-1:0]  d2l_ff [3];
   logic [2:0][QB-1:0]    d2b_ff [3];
   logic [2:0][QB-1:0]    bas    [3];

   assign bas[0] = side_d;
   assign bas[1] = tp_vec;
   assign bas[2] = front_d;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               d1h_ff[k][i] <= HB'($signed(bas[k][i])) * HB'($signed(eye_d[i][W-1:F]));
               d1l_ff[k][i] <= LB'($signed(bas[k][i])) * LB'($signed({1'b0, eye_d[i][F-1:0]}));
            end
            d2h_ff[k] <= HS'(d1h_ff[k][0]) + HS'(d1h_ff[k][1]) + HS'(d1h_ff[k][2]);
            d2l_ff[k] <= LS'(d1l_ff[k][0]) + LS'(d1l_ff[k][1]) + LS'(d1l_ff[k][2]);
         end
         d1b_ff <= bas;
         d2b_ff <= d1b_ff;
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         x1_v_ff <= 1'b0;
         x2_v_ff <= 1'b0;
         y1_v_ff <= 1'b0;
         y2_v_ff <= 1'b0;
         d1_v_ff <= 1'b0;
         d2_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_valid;
         x1_v_ff <= fr_valid;
         x2_v_ff <= x1_v_ff;
         y1_v_ff <= sd_valid;
         y2_v_ff <= y1_v_ff;
         d1_v_ff <= tp_valid;
         d2_v_ff <= d1_v_ff;
      end
   end

   // finish column 3 and saturate every entry on load into the serialiser
   logic [W-1:0] col_in [4][3];
   logic [W-1:0] one_w;

   always_comb begin
      logic signed [DW-1:0] hi;
      logic signed [DW-1:0] lo;
      for (int j = 0; j < 3; j++) begin
         col_in[j][0] = sat_word(DW'($signed(d2b_ff[0][j])));
         col_in[j][1] = sat_word(DW'($signed(d2b_ff[1][j])));
         col_in[j][2] = sat_word(DW'(0) - DW'($signed(d2b_ff[2][j])));
      end
      for (int k = 0; k < 3; k++) begin
         hi = DW'(d2h_ff[k]);
         lo = DW'(d2l_ff[k]);
         if (k == 2) begin
            col_in[3][k] = sat_word(hi + ((lo + HALF_D) >>> F));
         end else begin
            col_in[3][k] = sat_word((DW'(0) - hi) + ((HALF_D - lo) >>> F));
         end
      end
      one_w = sat_word(ONE_D);
   end

   // column serialiser: hold one matrix, hand out one column per transaction
   logic         busy_ff;
   logic [1:0]   cnt_ff;
   logic [W-1:0] col_ff [4][3];

   assign ser_free  = !busy_ff || (cnt_ff == lav_pkg::LAV_LAST_COL && rsp_ready);
   assign adv       = ser_free || !d2_v_ff;
   assign load      = d2_v_ff && ser_free;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         if (cnt_ff == lav_pkg::LAV_LAST_COL) begin
            busy_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         col_ff <= col_in;
      end
   end

   always_comb begin
      rsp_data.column_index = cnt_ff;
      rsp_data.row_zero     = col_ff[cnt_ff][0];
      rsp_data.row_one      = col_ff[cnt_ff][1];
      rsp_data.row_two      = col_ff[cnt_ff][2];
      rsp_data.last_column  = (cnt_ff == lav_pkg::LAV_LAST_COL);
      rsp_data.row_three    = rsp_data.last_column ? one_w : '0;
   end

   assign rsp_valid = busy_ff;

   // a taken column that is not the last is followed by the next column
   a_next_col : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_column |=>
         rsp_valid && rsp_data.column_index == $past(rsp_data.column_index) + 2'd1)
      else $error("column sequence broken");

   // after the last column, any following matrix starts at column 0
   a_restart : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_column |=>
         !rsp_valid || rsp_data.column_index == 2'd0)
      else $error("matrix did not restart at column 0");

   // input stalls only while a result is held on the output
   a_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !(rsp_ready && rsp_data.last_column))
      else $error("input stalled without a pending result");

endmodule

FILE: test/lav_checker.sv
// Scoreboard for the look-at view matrix block: watches both channels,
// predicts the four columns of each accepted transaction and compares them.
// Depends on lav_pkg.
`timescale 1ns / 1ps
module lav_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  lav_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  lav_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending,
   output int               matrices_seen
);

   typedef longint vec3_type [3];

   localparam longint ONE_Q = longint'(1) << lav_pkg::LAV_FRAC_BITS;
   localparam longint SMAX  = (longint'(1) <<< (lav_pkg::LAV_WORD_BITS - 1)) - 1;
   localparam longint SMIN  = -(longint'(1) <<< (lav_pkg::LAV_WORD_BITS - 1));

   lav_pkg::rsp_type expected_columns[$];

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Block-scale so the largest magnitude lies in [2^29, 2^30), then optionally
   // divide by the length to get a unit vector; a zero vector stays zero.
   function automatic void scale_vec(input vec3_type v, input bit to_unit,
                                     output vec3_type o);
      longint unsigned mag[3];
      bit              neg[3];
      longint unsigned m, sum, len, q;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         for (int i = 0; i < 3; i++) o[i] = 0;
         return;
      end
      while (m >= (longint'(1) << 30)) begin
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
         m = m >> 1;
      end
      while (m < (longint'(1) << 29)) begin
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         m = m << 1;
      end
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = to_unit ? ((mag[i] << lav_pkg::LAV_FRAC_BITS) + (len >> 1)) / len : mag[i];
         o[i] = neg[i] ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic void cross_vec(input vec3_type a, input vec3_type b,
                                     output vec3_type r);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   // Exact dot of a unit vector with a point, fraction rounded half up.
   function automatic longint dot_eye(input vec3_type q, input vec3_type e);
      longint hi, lo, el, eh;
      hi = 0;
      lo = 0;
      for (int i = 0; i < 3; i++) begin
         el = e[i] & (ONE_Q - 1);
         eh = (e[i] - el) / ONE_Q;
         hi += q[i] * eh;
         lo += q[i] * el;
      end
      return hi + ((lo + (ONE_Q >>> 1)) >>> lav_pkg::LAV_FRAC_BITS);
   endfunction

   function automatic logic [lav_pkg::LAV_WORD_BITS-1:0] clamp_word(input longint v);
      if (v > SMAX) v = SMAX;
      if (v < SMIN) v = SMIN;
      return v[lav_pkg::LAV_WORD_BITS-1:0];
   endfunction

   // Build the four expected column transactions of one request.
   function automatic void predict_matrix(input lav_pkg::req_type d);
      vec3_type         eye, diff, upv, upd, front, side, top, tmp, nside, ntop;
      longint           col3[3];
      lav_pkg::rsp_type c;
      eye  = '{longint'(d.eye_x), longint'(d.eye_y), longint'(d.eye_z)};
      upv  = '{longint'(d.up_x), longint'(d.up_y), longint'(d.up_z)};
      diff = '{longint'(d.target_x) - eye[0], longint'(d.target_y) - eye[1],
               longint'(d.target_z) - eye[2]};
      scale_vec(diff, 1'b1, front);
      scale_vec(upv, 1'b0, upd);
      cross_vec(front, upd, tmp);
      scale_vec(tmp, 1'b1, side);
      cross_vec(side, front, tmp);
      scale_vec(tmp, 1'b1, top);
      for (int i = 0; i < 3; i++) begin
         nside[i] = -side[i];
         ntop[i]  = -top[i];
      end
      col3[0] = dot_eye(nside, eye);
      col3[1] = dot_eye(ntop, eye);
      col3[2] = dot_eye(front, eye);
      for (int j = 0; j < 4; j++) begin
         c.column_index = j[1:0];
         if (j < 3) begin
            c.row_zero    = clamp_word(side[j]);
            c.row_one     = clamp_word(top[j]);
            c.row_two     = clamp_word(-front[j]);
            c.row_three   = '0;
            c.last_column = 1'b0;
         end else begin
            c.row_zero    = clamp_word(col3[0]);
            c.row_one     = clamp_word(col3[1]);
            c.row_two     = clamp_word(col3[2]);
            c.row_three   = clamp_word(ONE_Q);
            c.last_column = 1'b1;
         end
         expected_columns.push_back(c);
      end
   endfunction

   task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
      error_count++;
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, field, exp_v, act_v);
   endtask

   initial begin
      error_count   = 0;
      pending       = 0;
      matrices_seen = 0;
   end

   // Record requests and check columns on each handshake
   always @(posedge clock) begin
      lav_pkg::rsp_type e;
      if (!reset) begin
         if (req_valid && req_ready) predict_matrix(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_columns.size() == 0) begin
               error_count++;
               $display("%0t: unexpected column transaction %h", $time, rsp_data);
            end else begin
               e = expected_columns.pop_front();
               if (rsp_data.column_index !== e.column_index)
                  report("column_index", e.column_index, rsp_data.column_index);
               if (rsp_data.row_zero !== e.row_zero)
                  report("row_zero", e.row_zero, rsp_data.row_zero);
               if (rsp_data.row_one !== e.row_one)
                  report("row_one", e.row_one, rsp_data.row_one);
               if (rsp_data.row_two !== e.row_two)
                  report("row_two", e.row_two, rsp_data.row_two);
               if (rsp_data.row_three !== e.row_three)
                  report("row_three", e.row_three, rsp_data.row_three);
               if (rsp_data.last_column !== e.last_column)
                  report("last_column", e.last_column, rsp_data.last_column);
               if (e.last_column) matrices_seen++;
            end
         end
         pending = expected_columns.size();
      end
   end

endmodule

FILE: test/tb_look_at_view_matrix.sv
// Top of the look-at view matrix testbench: clock, reset, stimulus and verdict.
// Depends on lav_pkg, look_at_view_matrix and lav_checker.
`timescale 1ns / 1ps
module tb_look_at_view_matrix;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   lav_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   lav_pkg::rsp_type rsp_data;

   int error_count, pending, matrices_seen;
   int tx_idle_pct = 37;
   int rx_idle_pct = 65;
   bit hold_go = 1'b0;
   int sent = 0;

   localparam logic signed [31:0] WMAX = 32'sh7fffffff;
   localparam logic signed [31:0] WMIN = 32'sh80000000;
   localparam logic signed [31:0] QONE = 32'sh00010000;

   look_at_view_matrix dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   lav_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .error_count(error_count), .pending(pending), .matrices_seen(matrices_seen)
   );

   always #4 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #8ms;
      $display("tb: failure");
      $finish;
   end

   // Receiver: random back-pressure plus one long hold-off on request
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            hold = 800;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offer one request and hold it until accepted, then maybe idle
   task automatic send(input lav_pkg::req_type d);
      logic rdy;
      req_data  <= d;
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
      end while (!rdy);
      sent++;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
         2: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
         default: return $signed($urandom) >>> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic lav_pkg::req_type rand_req();
      lav_pkg::req_type d;
      d.eye_x = rand_word(); d.eye_y = rand_word(); d.eye_z = rand_word();
      d.target_x = rand_word(); d.target_y = rand_word(); d.target_z = rand_word();
      d.up_x = rand_word(); d.up_y = rand_word(); d.up_z = rand_word();
      // now and then make degenerate geometry
      case ($urandom_range(15))
         0: {d.target_x, d.target_y, d.target_z} = {d.eye_x, d.eye_y, d.eye_z};
         1: {d.up_x, d.up_y, d.up_z} = '0;
         2: {d.up_x, d.up_y, d.up_z} = {d.target_x - d.eye_x, d.target_y - d.eye_y,
                                        d.target_z - d.eye_z};
         default: ;
      endcase
      return d;
   endfunction

   function automatic lav_pkg::req_type mk(input logic signed [31:0] ex, ey, ez, tx, ty, tz,
                                           ux, uy, uz);
      return '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
   endfunction

   task automatic run_random(input int n);
      repeat (n) send(rand_req());
   endtask

   // Stimulus and verdict
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: typical camera, degenerate cases and word extremes
      send(mk(0, 0, 5 * QONE, 0, 0, 0, 0, QONE, 0));
      send(mk(QONE, 2 * QONE, 3 * QONE, QONE, 2 * QONE, 3 * QONE, 0, QONE, 0));
      send(mk(0, 0, 0, QONE, 0, 0, 0, 0, 0));
      send(mk(0, 0, 0, 0, QONE, 0, 0, QONE, 0));
      send(mk(0, 0, 0, 0, -QONE, 0, 0, 3 * QONE, 0));
      send(mk(WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, 0, QONE, 0));
      send(mk(WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, WMAX, WMIN, WMAX));
      send(mk(WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMIN, WMIN, WMIN));
      send(mk(WMIN, 0, WMAX, 0, 0, 0, 1, 0, 0));
      send(mk(-1, -1, -1, 0, 0, 0, -1, 1, 0));
      send(mk(32'sh7fff8000, 32'sh80008000, 32'sh12345678, 0, 0, 0, 0, 0, 1));
      send(mk(32'shffffffff, 32'sh00000001, 32'sh0000ffff, 32'sh55555555,
              32'shaaaaaaaa, 32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh33333333, 32'shcccccccc));
      send(mk(QONE, QONE, QONE, 2 * QONE, 2 * QONE, 2 * QONE, -QONE, -QONE, -QONE));

      run_random(130);
      tx_idle_pct = 65;
      rx_idle_pct = 37;
      run_random(120);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_go = 1'b1;
      run_random(130);

      // drop valid at the edge that took the last request
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("tb: %0d requests sent, %0d matrices checked", sent, matrices_seen);
      $display("tb: covered degenerate geometry, word extremes, stalls and a full pipe");
      if (error_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
